@@ hdl/fcce_pkg.sv @@
// Shared types, constants and helpers for the FAT cluster chain engine.
package fcce_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned CLUS_W      = 28;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FUNC_W      = 3;

  localparam logic [CLUS_W-1:0] END_OF_CHAIN     = 28'hFFFFFF8;
  localparam logic [CLUS_W-1:0] BAD_CLUSTER_MARK = 28'hFFFFFF7;
  localparam logic [CLUS_W-1:0] MIN_CLUSTER      = 28'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_FREE       = 3'd1,
    FN_WALK_START = 3'd2,
    FN_WALK_NEXT  = 3'd3,
    FN_WRITE      = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_FREE_RD,
    S_WALK_CHK,
    S_WALK_RD,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SCAN,
    CMD_READ,
    CMD_FREE_WR,
    CMD_WALK_END,
    CMD_WALK_UPD
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_miss;
    logic walk_ok;
    logic link_end;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [CLUS_W-1:0] cluster;
    logic              found;
    logic              chain_end;
  } res_t;

  // A cluster may be followed if it lies in the data area of the active table.
  function automatic logic walkable(input logic [CLUS_W-1:0] c,
                                    input logic [SIZE_W-1:0] size);
    return (c >= MIN_CLUSTER) && (c < CLUS_W'(size)) && (c < BAD_CLUSTER_MARK);
  endfunction

endpackage

@@ hdl/fcce_ctrl.sv @@
// Controller state machine sequencing table sweeps, scans, chain walks and responses.
module fcce_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic [2:0]            req_func_i,
  output logic                  req_ready_o,
  input  fcce_pkg::dp_stat_t    stat_i,
  output fcce_pkg::ctrl_cmd_t   cmd_o
);

  fcce_pkg::state_e state_q, state_d;
  fcce_pkg::func_e  func;
  logic             accept;

  assign func        = fcce_pkg::func_e'(req_func_i);
  assign req_ready_o = (state_q == fcce_pkg::S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcce_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcce_pkg::S_CLEAR: begin
        if (stat_i.clear_last) state_d = fcce_pkg::S_IDLE;
      end
      fcce_pkg::S_IDLE: begin
        if (accept) begin
          case (func)
            fcce_pkg::FN_ALLOC: state_d = fcce_pkg::S_SCAN;
            fcce_pkg::FN_FREE:  state_d = fcce_pkg::S_FREE_CHK;
            fcce_pkg::FN_WALK_START,
            fcce_pkg::FN_WALK_NEXT: state_d = fcce_pkg::S_WALK_CHK;
            default:            state_d = fcce_pkg::S_RESP;
          endcase
        end
      end
      fcce_pkg::S_SCAN: begin
        if (stat_i.scan_hit || stat_i.scan_miss) state_d = fcce_pkg::S_RESP;
      end
      fcce_pkg::S_FREE_CHK: begin
        state_d = stat_i.walk_ok ? fcce_pkg::S_FREE_RD : fcce_pkg::S_RESP;
      end
      fcce_pkg::S_FREE_RD: begin
        state_d = stat_i.link_end ? fcce_pkg::S_RESP : fcce_pkg::S_FREE_CHK;
      end
      fcce_pkg::S_WALK_CHK: begin
        state_d = stat_i.walk_ok ? fcce_pkg::S_WALK_RD : fcce_pkg::S_RESP;
      end
      fcce_pkg::S_WALK_RD: begin
        state_d = fcce_pkg::S_RESP;
      end
      fcce_pkg::S_RESP: begin
        if (stat_i.out_free) state_d = fcce_pkg::S_IDLE;
      end
      default: state_d = fcce_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.op       = fcce_pkg::CMD_IDLE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      fcce_pkg::S_CLEAR:    cmd_o.op = fcce_pkg::CMD_CLEAR;
      fcce_pkg::S_IDLE: begin
        if (accept) cmd_o.op = fcce_pkg::CMD_LOAD;
      end
      fcce_pkg::S_SCAN:     cmd_o.op = fcce_pkg::CMD_SCAN;
      fcce_pkg::S_FREE_CHK: begin
        if (stat_i.walk_ok) cmd_o.op = fcce_pkg::CMD_READ;
      end
      fcce_pkg::S_FREE_RD:  cmd_o.op = fcce_pkg::CMD_FREE_WR;
      fcce_pkg::S_WALK_CHK: begin
        cmd_o.op = stat_i.walk_ok ? fcce_pkg::CMD_READ : fcce_pkg::CMD_WALK_END;
      end
      fcce_pkg::S_WALK_RD:  cmd_o.op = fcce_pkg::CMD_WALK_UPD;
      fcce_pkg::S_RESP:     cmd_o.out_load = stat_i.out_free;
      default:              cmd_o.op = fcce_pkg::CMD_IDLE;
    endcase
  end

endmodule

@@ hdl/fcce_dp.sv @@
// Datapath: allocation table memory, scan and chain registers, output register.
module fcce_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcce_pkg::ctrl_cmd_t               cmd_i,
  output fcce_pkg::dp_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [fcce_pkg::SIZE_W-1:0]       cfg_wdata_i,
  input  logic [2:0]                        req_func_i,
  input  logic [fcce_pkg::CLUS_W-1:0]       req_cluster_i,
  input  logic [fcce_pkg::WORD_W-1:0]       req_link_i,
  output fcce_pkg::res_t                    out_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i
);

  logic [fcce_pkg::WORD_W-1:0] mem_q [fcce_pkg::TABLE_DEPTH];
  logic [fcce_pkg::WORD_W-1:0] rdata_q;

  logic [fcce_pkg::ADDR_W-1:0] clr_q;
  logic [fcce_pkg::SIZE_W-1:0] size_q;
  logic [fcce_pkg::SIZE_W-1:0] scan_q;
  logic [fcce_pkg::ADDR_W-1:0] idx_q;
  logic                        pend_q;
  logic [fcce_pkg::CLUS_W-1:0] cl_q;
  logic [fcce_pkg::CLUS_W-1:0] cursor_q;
  fcce_pkg::res_t              res_q;
  fcce_pkg::res_t              out_q;
  logic                        out_valid_q;

  logic                        we;
  logic [fcce_pkg::ADDR_W-1:0] waddr;
  logic [fcce_pkg::WORD_W-1:0] wdata;
  logic                        re;
  logic [fcce_pkg::ADDR_W-1:0] raddr;
  logic                        scan_issue;
  logic                        scan_hit;
  logic [fcce_pkg::CLUS_W-1:0] link;
  logic                        link_end;
  logic                        req_in_range;
  fcce_pkg::func_e             func;

  assign func         = fcce_pkg::func_e'(req_func_i);
  assign scan_issue   = scan_q < size_q;
  assign scan_hit     = pend_q && (rdata_q == '0);
  assign link         = rdata_q[fcce_pkg::CLUS_W-1:0];
  assign link_end     = link >= fcce_pkg::END_OF_CHAIN;
  assign req_in_range = req_cluster_i < fcce_pkg::CLUS_W'(size_q);

  assign stat_o.clear_last = clr_q == fcce_pkg::ADDR_W'(fcce_pkg::TABLE_DEPTH - 1);
  assign stat_o.scan_hit   = scan_hit;
  assign stat_o.scan_miss  = !pend_q && !scan_issue;
  assign stat_o.walk_ok    = fcce_pkg::walkable(cl_q, size_q);
  assign stat_o.link_end   = link_end;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    re    = 1'b0;
    raddr = cl_q[fcce_pkg::ADDR_W-1:0];
    unique case (cmd_i.op)
      fcce_pkg::CMD_CLEAR: we = 1'b1;
      fcce_pkg::CMD_LOAD: begin
        we    = (func == fcce_pkg::FN_WRITE) && req_in_range;
        waddr = req_cluster_i[fcce_pkg::ADDR_W-1:0];
        wdata = req_link_i;
      end
      fcce_pkg::CMD_SCAN: begin
        we    = scan_hit;
        waddr = idx_q;
        wdata = fcce_pkg::WORD_W'(fcce_pkg::END_OF_CHAIN);
        re    = scan_issue;
        raddr = scan_q[fcce_pkg::ADDR_W-1:0];
      end
      fcce_pkg::CMD_READ: re = 1'b1;
      fcce_pkg::CMD_FREE_WR: begin
        we    = 1'b1;
        waddr = cl_q[fcce_pkg::ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem_q[raddr];
  end

  // Control registers: sweep pointer, active size, scan pending, cursor, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      size_q      <= fcce_pkg::SIZE_W'(fcce_pkg::TABLE_DEPTH);
      pend_q      <= 1'b0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == fcce_pkg::CMD_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        size_q <= (cfg_wdata_i > fcce_pkg::SIZE_W'(fcce_pkg::TABLE_DEPTH)) ?
                  fcce_pkg::SIZE_W'(fcce_pkg::TABLE_DEPTH) : cfg_wdata_i;
      end
      if (cmd_i.op == fcce_pkg::CMD_LOAD) pend_q <= 1'b0;
      else if (cmd_i.op == fcce_pkg::CMD_SCAN) pend_q <= scan_issue;
      if (cmd_i.op == fcce_pkg::CMD_LOAD && func == fcce_pkg::FN_WALK_START) begin
        cursor_q <= req_cluster_i;
      end else if (cmd_i.op == fcce_pkg::CMD_WALK_UPD) begin
        cursor_q <= (link_end || !fcce_pkg::walkable(link, size_q)) ? '0 : link;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      fcce_pkg::CMD_LOAD: begin
        scan_q <= fcce_pkg::SIZE_W'(fcce_pkg::MIN_CLUSTER);
        cl_q   <= (func == fcce_pkg::FN_WALK_NEXT) ? cursor_q : req_cluster_i;
        res_q  <= '0;
      end
      fcce_pkg::CMD_SCAN: begin
        if (scan_issue) begin
          scan_q <= scan_q + 1'b1;
          idx_q  <= scan_q[fcce_pkg::ADDR_W-1:0];
        end
        if (scan_hit) res_q <= '{cluster: fcce_pkg::CLUS_W'(idx_q), found: 1'b1,
                                 chain_end: 1'b1};
      end
      fcce_pkg::CMD_FREE_WR: cl_q <= link;
      fcce_pkg::CMD_WALK_END: res_q <= '{cluster: '0, found: 1'b0, chain_end: 1'b1};
      fcce_pkg::CMD_WALK_UPD: begin
        res_q <= '{cluster: cl_q, found: 1'b1,
                   chain_end: link_end || !fcce_pkg::walkable(link, size_q)};
      end
      default: ;
    endcase
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/fat_cluster_chain_engine.sv @@
// Top level of the FAT cluster chain engine: controller, datapath and stream ports.
//
//   Channel   Dir  Handshake                 Payload
//   s_axis    in   s_axis_tvalid/tready      tuser func, tdata cluster, link_value
//   m_axis    out  m_axis_tvalid/tready      tdata result_cluster, tuser found,
//                                            tlast chain_end
//   cfg       in   cfg_we                    cfg_wdata entries_in_use
//
// Each request runs from its accept cycle through the cycle that loads the result
// into the output register. Allocate scans the table from index 2, one table read
// per cycle over the single read port, until it finds a free entry or reaches
// entries_in_use. Free chain reads each link, then zeroes it, until the chain ends
// or stops at a cluster that cannot be followed; walk reads the cursor's entry
// only when the cursor can be followed; write and unused codes go straight to the
// response. One request is in flight at a time.
// After reset the table is swept to zero, one word a cycle, over all 4096 entries;
// s_axis_tready stays low during the sweep, config writes are taken throughout.
// A result waiting on m_axis does not block the next request; only a second
// result waits until the first one is taken.
module fat_cluster_chain_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [27:0] cluster, [59:28] link_value, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [27:0] result_cluster, rest zero
  output logic        m_axis_tuser,   // [0] found
  output logic        m_axis_tlast,   // chain_end
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i     // entries_in_use
);

  fcce_pkg::ctrl_cmd_t cmd;
  fcce_pkg::dp_stat_t  stat;
  fcce_pkg::res_t      out;

  // Sequence each request.
  fcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_func_i  (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the table, the walk cursor and the result register.
  fcce_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_func_i    (s_axis_tuser),
    .req_cluster_i (s_axis_tdata[27:0]),
    .req_link_i    (s_axis_tdata[59:28]),
    .out_o         (out),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, out.cluster};
  assign m_axis_tuser = out.found;
  assign m_axis_tlast = out.chain_end;

endmodule
